>>> design/cfh_pkg.sv
package cfh_pkg;

    localparam int MAX_DATA_BYTES = 8;

    localparam int ID_W      = 29;
    localparam int LEN_W     = 4;
    localparam int PAYLOAD_W = 64;
    localparam int CHAR_W    = 8;
    localparam int DIGIT_W   = 3;
    localparam int BYTE_IDX_W = 3;

    localparam logic [DIGIT_W-1:0] STD_TOP_DIGIT = 3'd2;
    localparam logic [DIGIT_W-1:0] EXT_TOP_DIGIT = 3'd7;

    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    typedef struct packed {
        logic                 extended_id;
        logic [ID_W-1:0]      identifier;
        logic [LEN_W-1:0]     data_length;
        logic [PAYLOAD_W-1:0] payload;
    } frame_in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } text_out_t;

    // classified frame handed from front to back
    typedef struct packed {
        logic [DIGIT_W-1:0]   top_digit;
        logic [ID_W-1:0]      identifier;
        logic [LEN_W-1:0]     length;
        logic [PAYLOAD_W-1:0] payload;
    } job_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ID,
        PH_SP_LEN,
        PH_LEN,
        PH_SP_BYTE,
        PH_HI,
        PH_LO,
        PH_CR,
        PH_LF
    } phase_t;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
        logic [CHAR_W-1:0] wide;
        wide = {4'h0, nib};
        if (nib < 4'd10)
            return 8'h30 + wide;
        else
            return 8'h37 + wide;
    endfunction

endpackage

>>> design/cfh_front.sv
module cfh_front (
    input  cfh_pkg::frame_in_t frame,
    input  logic               frame_valid,
    output logic               frame_stall,
    input  logic               queue_full,
    output logic               push,
    output cfh_pkg::job_t      job
);
    import cfh_pkg::*;

    assign frame_stall = queue_full;
    assign push        = frame_valid && !queue_full;

    always_comb
    begin
        job.top_digit  = frame.extended_id ? EXT_TOP_DIGIT : STD_TOP_DIGIT;
        job.identifier = frame.identifier;
        job.payload    = frame.payload;
        // lengths above the byte limit print as the limit
        if (frame.data_length > LEN_W'(MAX_DATA_BYTES))
            job.length = LEN_W'(MAX_DATA_BYTES);
        else
            job.length = frame.data_length;
    end

endmodule

>>> design/cfh_queue.sv
module cfh_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cfh_pkg::job_t din,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output cfh_pkg::job_t dout
);
    import cfh_pkg::*;

    job_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign dout      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= din;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3) else $error("queue count out of range");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty) else $error("pop from empty queue");
`endif

endmodule

>>> design/cfh_back.sv
module cfh_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              queue_not_empty,
    input  cfh_pkg::job_t     queue_head,
    output logic              pop,
    output cfh_pkg::text_out_t text,
    output logic              text_valid,
    input  logic              text_stall
);
    import cfh_pkg::*;

    phase_t                phase_reg, phase_next;
    job_t                  job_reg, job_next;
    logic [DIGIT_W-1:0]    digit_reg, digit_next;
    logic [BYTE_IDX_W-1:0] byte_reg, byte_next;
    text_out_t             out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  room;
    logic                  emit;
    logic                  last_byte;
    logic [31:0]           id_wide;
    logic [7:0]            cur_byte;
    text_out_t             cur_char;

    assign room      = !out_valid_reg || !text_stall;
    assign emit      = (phase_reg != PH_IDLE) && room;
    assign last_byte = ({1'b0, byte_reg} + 4'd1) == job_reg.length;
    assign id_wide   = {3'b000, job_reg.identifier};
    assign cur_byte  = job_reg.payload[{byte_reg, 3'b000} +: 8];

    assign text       = out_reg;
    assign text_valid = out_valid_reg;

    // next phase and sequencing counters
    always_comb
    begin
        phase_next = phase_reg;
        job_next   = job_reg;
        digit_next = digit_reg;
        byte_next  = byte_reg;
        pop        = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (queue_not_empty)
                begin
                    pop        = 1'b1;
                    job_next   = queue_head;
                    digit_next = queue_head.top_digit;
                    phase_next = PH_ID;
                end
            end
            PH_ID:
            begin
                if (room)
                begin
                    if (digit_reg == '0)
                        phase_next = PH_SP_LEN;
                    else
                        digit_next = digit_reg - 1'b1;
                end
            end
            PH_SP_LEN:
            begin
                if (room)
                    phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                if (room)
                begin
                    byte_next  = '0;
                    phase_next = (job_reg.length == '0) ? PH_CR : PH_SP_BYTE;
                end
            end
            PH_SP_BYTE:
            begin
                if (room)
                    phase_next = PH_HI;
            end
            PH_HI:
            begin
                if (room)
                    phase_next = PH_LO;
            end
            PH_LO:
            begin
                if (room)
                begin
                    if (last_byte)
                        phase_next = PH_CR;
                    else
                    begin
                        byte_next  = byte_reg + 1'b1;
                        phase_next = PH_SP_BYTE;
                    end
                end
            end
            PH_CR:
            begin
                if (room)
                    phase_next = PH_LF;
            end
            PH_LF:
            begin
                if (room)
                begin
                    // pick up the next frame straight away
                    if (queue_not_empty)
                    begin
                        pop        = 1'b1;
                        job_next   = queue_head;
                        digit_next = queue_head.top_digit;
                        phase_next = PH_ID;
                    end
                    else
                        phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // character for the current phase
    always_comb
    begin
        cur_char.last = 1'b0;
        unique case (phase_reg)
            PH_ID:      cur_char.character = hex_char(id_wide[{digit_reg, 2'b00} +: 4]);
            PH_SP_LEN:  cur_char.character = CHAR_SPACE;
            PH_LEN:     cur_char.character = hex_char(job_reg.length);
            PH_SP_BYTE: cur_char.character = CHAR_SPACE;
            PH_HI:      cur_char.character = hex_char(cur_byte[7:4]);
            PH_LO:      cur_char.character = hex_char(cur_byte[3:0]);
            PH_CR:      cur_char.character = CHAR_CR;
            PH_LF:
            begin
                cur_char.character = CHAR_LF;
                cur_char.last      = 1'b1;
            end
            default:    cur_char.character = CHAR_SPACE;
        endcase

        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (room)
        begin
            out_next       = cur_char;
            out_valid_next = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        digit_reg <= digit_next;
        byte_reg  <= byte_next;
        out_reg   <= out_next;
    end

`ifndef SYNTH
    a_last_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
        (text_valid && text.last) |-> (text.character == CHAR_LF))
        else $error("last flag on a character other than line feed");
    a_pop_phase: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (phase_reg == PH_IDLE || phase_reg == PH_LF))
        else $error("frame taken mid line");
    a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ID) |-> (digit_reg <= job_reg.top_digit))
        else $error("identifier digit beyond frame width");
    a_byte_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HI || phase_reg == PH_LO) |->
        ({1'b0, byte_reg} < job_reg.length))
        else $error("data byte index beyond length");
`endif

endmodule

>>> design/can_frame_to_hex_text_core.sv
// channel | dir | payload           | handshake
// frame   | in  | frame_in_t        | frame_valid / frame_stall
// text    | out | text_out_t        | text_valid / text_stall
//
// one character per cycle leaves the output register while text_stall is low;
// a frame gives 7 to 36 characters
// a two-entry queue holds classified frames, so up to two more can be taken
// while a line is being sent
// reset clears the queue pointers, sequencer phase and output valid
// a stall on text holds the character and freezes the sequencer
module can_frame_to_hex_text_core (
    input  logic               clk,
    input  logic               rst_n,
    input  cfh_pkg::frame_in_t frame,
    input  logic               frame_valid,
    output logic               frame_stall,
    output cfh_pkg::text_out_t text,
    output logic               text_valid,
    input  logic               text_stall
);
    import cfh_pkg::*;

    job_t front_job;
    job_t queue_head;
    logic queue_full;
    logic queue_not_empty;
    logic push;
    logic pop;

    cfh_front u_front (
        .frame       (frame),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .queue_full  (queue_full),
        .push        (push),
        .job         (front_job)
    );

    cfh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .din       (front_job),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .dout      (queue_head)
    );

    cfh_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .queue_not_empty (queue_not_empty),
        .queue_head      (queue_head),
        .pop             (pop),
        .text            (text),
        .text_valid      (text_valid),
        .text_stall      (text_stall)
    );

endmodule
